>>> sv/mocs_pkg.sv
// Shared types and constants for the Manhattan-order cell scanner.
package mocs_pkg;

  // Default largest grid dimension.
  localparam int MAX_DIM_DEFAULT = 128;

  // Field widths of the stream and configuration channels.
  localparam int COORD_W   = 7;
  localparam int DIM_W     = 8;
  localparam int DIST_W    = 8;
  localparam int OFFSET_W  = 9;
  localparam int COUNT_W   = 15;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 8;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 8'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;  // start the scan over at the center
    logic step;   // examine one candidate cell
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic found;  // the current candidate lies inside the grid
  } status_t;

endpackage

>>> sv/mocs_ctrl.sv
// Controller state machine of the Manhattan-order cell scanner.
module mocs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  output logic            m_tvalid,
  input  logic            m_tready,
  output mocs_pkg::cmd_t  cmd,
  input  mocs_pkg::status_t status
);
  import mocs_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic state;
  logic state_next;
  logic out_free;
  logic accept;
  logic emit;

  assign s_tready = !rst && (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd.clear  = 1'b0;
    cmd.step   = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.clear  = s_tdata[0];
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // Hold the walk while the output register is still occupied.
        if (out_free) begin
          cmd.step = 1'b1;
          if (status.found) begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/mocs_datapath.sv
// Datapath of the Manhattan-order cell scanner: registers, walk state, result register.
module mocs_datapath #(
  parameter int MAX_DIM = mocs_pkg::MAX_DIM_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [mocs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mocs_pkg::CFG_DAT_W-1:0] cfg_data,
  input  mocs_pkg::cmd_t                 cmd,
  output mocs_pkg::status_t              status,
  output logic [mocs_pkg::COORD_W-1:0]   out_row,
  output logic [mocs_pkg::COORD_W-1:0]   out_col,
  output logic [mocs_pkg::DIST_W-1:0]    out_dist,
  output logic                           out_last
);
  import mocs_pkg::*;

  // Output fields are 7 bits wide, so no dimension goes past 128.
  localparam int DIM_CAP_I = (MAX_DIM < 128) ? MAX_DIM : 128;
  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DIM_CAP_I);

  logic [DIM_W-1:0]   num_rows;
  logic [DIM_W-1:0]   num_cols;
  logic [COORD_W-1:0] center_row;
  logic [COORD_W-1:0] center_col;

  logic [DIST_W-1:0]   current_distance;
  logic [OFFSET_W-1:0] row_offset;
  logic                column_side;
  logic [COUNT_W-1:0]  cells_emitted;

  logic [DIST_W-1:0]   current_distance_next;
  logic [OFFSET_W-1:0] row_offset_next;
  logic                column_side_next;
  logic [COUNT_W-1:0]  cells_emitted_next;

  logic [DIM_W-1:0]    rows;
  logic [DIM_W-1:0]    cols;
  logic [COORD_W-1:0]  cr;
  logic [COORD_W-1:0]  cc;
  logic [DIST_W:0]     maxd;
  logic [COUNT_W-1:0]  total;
  logic [9:0]          reach;
  logic [OFFSET_W:0]   d_plus;
  logic [OFFSET_W-1:0] dr;
  logic [DIST_W-1:0]   k;
  logic [OFFSET_W-1:0] cc_plus_k;
  logic                found;
  logic [COORD_W-1:0]  col_pick;
  logic [COUNT_W-1:0]  count_inc;
  logic                last;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] t;
    t = (v == '0) ? DIM_W'(1) : v;
    if (t > DIM_CAP) t = DIM_CAP;
    return t;
  endfunction

  // Effective grid and clamped center.
  always_comb begin
    rows  = eff_dim(num_rows);
    cols  = eff_dim(num_cols);
    cr    = ({1'b0, center_row} > rows - 1'b1) ? COORD_W'(rows - 1'b1) : center_row;
    cc    = ({1'b0, center_col} > cols - 1'b1) ? COORD_W'(cols - 1'b1) : center_col;
    maxd  = {1'b0, rows} + {1'b0, cols} - (DIST_W+1)'(2);
    total = COUNT_W'(rows) * COUNT_W'(cols);
  end

  // One candidate of the diamond walk per step.
  always_comb begin
    current_distance_next = current_distance;
    row_offset_next       = row_offset;
    column_side_next      = column_side;
    cells_emitted_next    = cells_emitted;
    found                 = 1'b0;
    col_pick              = cc;
    reach     = 10'(cr) + 10'(current_distance);
    d_plus    = 10'(current_distance) + 10'd1;
    dr        = (row_offset > OFFSET_W'(cr)) ? row_offset - OFFSET_W'(cr)
                                             : OFFSET_W'(cr) - row_offset;
    k         = current_distance - DIST_W'(dr);
    cc_plus_k = OFFSET_W'(cc) + OFFSET_W'(k);
    count_inc = cells_emitted + 1'b1;
    last      = count_inc >= total;

    if ({1'b0, current_distance} > maxd) begin
      // Radius ran past the grid: start the scan over.
      current_distance_next = '0;
      row_offset_next       = '0;
      column_side_next      = 1'b0;
      cells_emitted_next    = '0;
    end else if (row_offset >= OFFSET_W'(rows) || 10'(row_offset) > reach) begin
      current_distance_next = DIST_W'(d_plus);
      row_offset_next       = (10'(cr) > d_plus) ? OFFSET_W'(10'(cr) - d_plus) : '0;
      column_side_next      = 1'b0;
    end else if (dr > OFFSET_W'(current_distance)) begin
      row_offset_next  = row_offset + 1'b1;
      column_side_next = 1'b0;
    end else if (!column_side) begin
      found    = (k <= DIST_W'(cc));
      col_pick = cc - COORD_W'(k);
      if (k != '0) begin
        column_side_next = 1'b1;
      end else begin
        row_offset_next = row_offset + 1'b1;
      end
    end else begin
      found            = (k != '0) && (cc_plus_k < OFFSET_W'(cols));
      col_pick         = COORD_W'(cc_plus_k);
      row_offset_next  = row_offset + 1'b1;
      column_side_next = 1'b0;
    end

    if (found) begin
      cells_emitted_next = count_inc;
      if (last) begin
        current_distance_next = '0;
        row_offset_next       = '0;
        column_side_next      = 1'b0;
        cells_emitted_next    = '0;
      end
    end
  end

  assign status.found = found;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows         <= DIM_W'(1);
      num_cols         <= DIM_W'(1);
      center_row       <= '0;
      center_col       <= '0;
      current_distance <= '0;
      row_offset       <= '0;
      column_side      <= 1'b0;
      cells_emitted    <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_NUM_ROWS:   num_rows   <= cfg_data;
          REG_NUM_COLS:   num_cols   <= cfg_data;
          REG_CENTER_ROW: center_row <= cfg_data[COORD_W-1:0];
          REG_CENTER_COL: center_col <= cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        current_distance <= '0;
        row_offset       <= '0;
        column_side      <= 1'b0;
        cells_emitted    <= '0;
      end else if (cmd.step) begin
        current_distance <= current_distance_next;
        row_offset       <= row_offset_next;
        column_side      <= column_side_next;
        cells_emitted    <= cells_emitted_next;
      end
    end
  end

  // Result register, loaded when a step lands on a grid cell.
  always_ff @(posedge clk) begin
    if (cmd.step && found) begin
      out_row  <= row_offset[COORD_W-1:0];
      out_col  <= col_pick;
      out_dist <= current_distance;
      out_last <= last;
    end
  end

endmodule

>>> sv/manhattan_order_cell_scanner_core.sv
// Top level of the Manhattan-order cell scanner.
//
//   Channel  Dir  Handshake               Payload
//   s_*      in   s_tvalid / s_tready     s_tdata[0] = restart
//   m_*      out  m_tvalid / m_tready     m_tdata = row, col, distance; m_tlast = last cell
//   cfg_*    in   cfg_valid / cfg_ready   cfg_index selects the register, cfg_data its value
//
// After a request is accepted, the single walk unit examines one candidate cell per cycle
// while the output register is free. A row that is off the grid on both sides costs two
// candidates, so on a narrow grid one cell can take a few hundred candidates, and a restart or
// a wrap climbs from row zero with center_row + 1 candidates. After a mid-scan reconfiguration
// the walk may sweep empty radii, up to about 66000 candidates, before it wraps to the center.
// Reset restores the register defaults (one by one grid, center at the origin) and clears
// the walk; there is no clearing pass. A result held in the output register does not block
// the next request, but the walk does not step while that register is full.
module manhattan_order_cell_scanner_core #(
  parameter int MAX_DIM = mocs_pkg::MAX_DIM_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mocs_pkg::IN_DATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mocs_pkg::OUT_DATA_W-1:0] m_tdata,   // [6:0] cell_row, [13:7] cell_col,
                                                     // [21:14] cell_distance, [23:22] zero
  output logic                            m_tlast,   // last_cell
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mocs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mocs_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import mocs_pkg::*;

  cmd_t               cmd;
  status_t            status;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic [DIST_W-1:0]  out_dist;

  // Registers can be written at any time outside reset.
  assign cfg_ready = !rst;

  mocs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  mocs_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_dist  (out_dist),
    .out_last  (m_tlast)
  );

  // Pack the result fields, lowest field first, padded to whole bytes.
  assign m_tdata = {2'b00, out_dist, out_col, out_row};

endmodule

>>> sv/mocs_checker.sv
// Port-level assertions for the Manhattan-order cell scanner, bound to the top level.
module mocs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mocs_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tlast
);
  import mocs_pkg::*;

  // A stalled result stays offered.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result payload changed while stalled");

  // After a request is taken the block is busy searching.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while a search was pending");

  // A fresh result only appears at the end of a search.
  a_result_after_search: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a search");

endmodule

bind manhattan_order_cell_scanner_core mocs_checker u_mocs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Manhattan-order cell scanner core.
module tb_top;
  import mocs_pkg::*;

  // Clock period is 8 ns.
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 6;
  // Exactly this many requests are sent after the directed script.
  localparam int RANDOM_REQUESTS = 1350;
  // The sender and the receiver each idle with a chance of 38 percent at every step.
  localparam int IDLE_PERCENT = 38;
  // How long the receiver refuses results during the back-pressure phase.
  localparam int HOLD_CYCLES = 300;
  // A single request can walk every radius of a full grid after a mid-scan
  // reconfiguration, about 66000 candidates, and the receiver hold comes on
  // top of that, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 300000;
  // Quiet time after the last result, to catch stray extra results.
  localparam int SETTLE_CYCLES = 20;
  // Random phases with special treatment.
  localparam int HOLD_PHASE = 2;
  localparam int PAUSE_PHASE = 4;
  localparam int STEADY_PHASE = 6;
  // Dimensions are clamped to the smaller of the build parameter and 128.
  localparam int DIM_CAP = (MAX_DIM_DEFAULT < 128) ? MAX_DIM_DEFAULT : 128;

  // One emitted cell, packed in the same order as {m_tlast, m_tdata[21:0]}.
  typedef struct packed {
    logic       last;
    logic [7:0] distance;
    logic [6:0] col;
    logic [6:0] row;
  } cell_t;

  // One line of the directed script: either a register write or a request.
  typedef enum bit {ACT_WRITE, ACT_SCAN} action_e;
  typedef struct packed {
    action_e                 act;
    logic [CFG_IDX_W-1:0]    index;
    logic [CFG_DAT_W-1:0]    value;
    logic                    restart;
    bit                      known;  // the expected cell is typed into the row
    cell_t                   expected;
  } script_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DAT_W-1:0]  cfg_data;

  // Shared controls between the stimulus process and the receiver.
  bit no_idle;   // both sides run flat out while this is set
  bit hold_req;  // set by the stimulus, cleared by the receiver when its hold ends

  cell_t       pending_cells[$];
  script_row_t script_rows[$];
  int unsigned failures;
  int unsigned quiet_cycles;

  // Shadow copy of the configuration registers.
  logic [7:0] cfg_rows;
  logic [7:0] cfg_cols;
  logic [6:0] cfg_crow;
  logic [6:0] cfg_ccol;

  // Shadow copy of the diamond walk.
  int unsigned walk_dist;
  int unsigned walk_row;
  bit          walk_right;
  logic [14:0] walk_count;

  manhattan_order_cell_scanner_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Cell order predictor
  // ---------------------------------------------------------------------------

  // A dimension of zero acts as one, and anything past the cap acts as the cap.
  function automatic int unsigned grid_span(input logic [7:0] v);
    int unsigned n;
    n = (v == 8'd0) ? 1 : v;
    if (n > DIM_CAP) n = DIM_CAP;
    return n;
  endfunction

  function automatic void rewind_walk();
    walk_dist  = 0;
    walk_row   = 0;
    walk_right = 1'b0;
    walk_count = '0;
  endfunction

  // Advances the walk to the next cell inside the grid. The walk visits the
  // diamond of radius walk_dist row by row from the top, trying the left
  // candidate of each row before the right one, so ties come out by row and
  // then by column. The candidates that fall off the grid are skipped.
  function automatic cell_t next_cell(input logic restart);
    int unsigned rows, cols, cr, cc, maxd, d, r, dr, k;
    bit          found;
    cell_t       c;
    rows  = grid_span(cfg_rows);
    cols  = grid_span(cfg_cols);
    cr    = (cfg_crow > rows - 1) ? rows - 1 : cfg_crow;
    cc    = (cfg_ccol > cols - 1) ? cols - 1 : cfg_ccol;
    maxd  = rows + cols - 2;
    found = 1'b0;
    c     = '0;
    if (restart) rewind_walk();
    while (!found) begin
      d = walk_dist;
      r = walk_row;
      if (d > maxd) begin
        // The radius ran past the far corner (only after a reconfiguration).
        rewind_walk();
      end else if (r >= rows || r > cr + d) begin
        walk_dist  = d + 1;
        walk_row   = (cr > d + 1) ? cr - (d + 1) : 0;
        walk_right = 1'b0;
      end else begin
        dr = (r > cr) ? r - cr : cr - r;
        if (dr > d) begin
          walk_row   = r + 1;
          walk_right = 1'b0;
        end else begin
          k = d - dr;
          if (!walk_right) begin
            if (k <= cc) begin
              c.col = 7'(cc - k);
              found = 1'b1;
            end
            // On the diamond's tips the left and right candidates coincide.
            if (k > 0) begin
              walk_right = 1'b1;
            end else begin
              walk_row = r + 1;
            end
          end else begin
            if (k > 0 && cc + k < cols) begin
              c.col = 7'(cc + k);
              found = 1'b1;
            end
            walk_row   = r + 1;
            walk_right = 1'b0;
          end
          if (found) begin
            c.row      = 7'(r);
            c.distance = 8'(d);
          end
        end
      end
    end
    walk_count = walk_count + 15'd1;
    c.last = (walk_count >= rows * cols);
    if (c.last) rewind_walk();
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed script builders
  // ---------------------------------------------------------------------------

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] val);
    script_row_t s;
    s = '0;
    s.act = ACT_WRITE;
    s.index = idx;
    s.value = val;
    script_rows.push_back(s);
  endfunction

  function automatic void add_scan(input logic restart);
    script_row_t s;
    s = '0;
    s.act = ACT_SCAN;
    s.restart = restart;
    script_rows.push_back(s);
  endfunction

  function automatic void add_known(input logic restart, input int unsigned row,
                                    input int unsigned col, input int unsigned dist_val,
                                    input logic last);
    script_row_t s;
    s = '0;
    s.act = ACT_SCAN;
    s.restart = restart;
    s.known = 1'b1;
    s.expected.row = 7'(row);
    s.expected.col = 7'(col);
    s.expected.distance = 8'(dist_val);
    s.expected.last = last;
    script_rows.push_back(s);
  endfunction

  // Dimensions at the edges of the register range, or anything at all.
  function automatic logic [7:0] pick_wide_dim();
    case ($urandom_range(4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd128;
      3: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offers one request and records the expected cell once it is accepted.
  // Idle cycles go in front of the request, so valid is never lowered and
  // raised again in the same time step.
  task automatic send_request(input logic restart, input bit known, input cell_t typed);
    cell_t predicted;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - 1){1'b0}}, restart};
    do @(posedge clk); while (!s_tready);
    predicted = next_cell(restart);
    pending_cells.push_back(known ? typed : predicted);
  endtask

  // Stops offering requests and waits until every expected cell has arrived.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
  endtask

  // Writes one register. Valid stays high for back-to-back writes and drops
  // after the final one of a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val, input bit final_write);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (final_write) cfg_valid <= 1'b0;
    case (idx)
      REG_NUM_ROWS:   cfg_rows = val;
      REG_NUM_COLS:   cfg_cols = val;
      REG_CENTER_ROW: cfg_crow = val[6:0];
      REG_CENTER_COL: cfg_ccol = val[6:0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver and checker
  // ---------------------------------------------------------------------------

  // The receiver stalls at random, except in the steady phase. When the
  // stimulus raises hold_req it refuses results for a long stretch so that the
  // core backs up and stops taking requests.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Each accepted cell is compared field by field with the oldest expectation.
  always @(posedge clk) begin : check_cells
    cell_t got;
    cell_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = cell_t'({m_tlast, m_tdata[21:0]});
      if (pending_cells.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected cell: row %0d col %0d dist %0d last %0d",
                   got.row, got.col, got.distance, got.last);
      end else begin
        want = pending_cells.pop_front();
        if (got.row !== want.row || got.col !== want.col ||
            got.distance !== want.distance || got.last !== want.last) begin
          failures++;
          if (failures <= 10)
            $display("Cell mismatch: expected row %0d col %0d dist %0d last %0d, ",
                     want.row, want.col, want.distance, want.last,
                     "got row %0d col %0d dist %0d last %0d",
                     got.row, got.col, got.distance, got.last);
        end
      end
    end
  end

  // The run is stuck if no channel completes a handshake for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [CFG_IDX_W-1:0] reg_order [4];
    logic [CFG_DAT_W-1:0] reg_vals [4];
    logic [3:0]           write_mask;
    int unsigned          issued, phase, n, total;
    bit                   wide, restart_first;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    failures  = 0;
    quiet_cycles = 0;
    cfg_rows  = 8'd1;
    cfg_cols  = 8'd1;
    cfg_crow  = 7'd0;
    cfg_ccol  = 7'd0;
    rewind_walk();
    reg_order = '{REG_NUM_ROWS, REG_NUM_COLS, REG_CENTER_ROW, REG_CENTER_COL};

    // After reset the grid is a single cell, so every request returns it as
    // the last cell, with or without a restart.
    add_known(1'b0, 0, 0, 0, 1'b1);
    add_known(1'b1, 0, 0, 0, 1'b1);
    // Zero rows act as one, oversized columns as 128, and an out-of-range
    // center is clamped to the last row and column: a 1 x 128 strip seen from
    // its right end.
    add_write(REG_NUM_ROWS, 8'd0);
    add_write(REG_NUM_COLS, 8'd255);
    add_write(REG_CENTER_ROW, 8'hFF);
    add_write(REG_CENTER_COL, 8'hFF);
    add_known(1'b1, 0, 127, 0, 1'b0);
    add_known(1'b0, 0, 126, 1, 1'b0);
    add_scan(1'b0);
    // The transposed case: a 128 x 1 column centered halfway down.
    add_write(REG_NUM_ROWS, 8'd255);
    add_write(REG_NUM_COLS, 8'd0);
    add_write(REG_CENTER_ROW, 8'h40);
    add_write(REG_CENTER_COL, 8'd0);
    add_known(1'b1, 64, 0, 0, 1'b0);
    add_known(1'b0, 63, 0, 1, 1'b0);
    add_known(1'b0, 65, 0, 1, 1'b0);
    // Full-size grid centered on the far corner.
    add_write(REG_NUM_ROWS, 8'd128);
    add_write(REG_NUM_COLS, 8'd128);
    add_write(REG_CENTER_ROW, 8'h7F);
    add_write(REG_CENTER_COL, 8'h7F);
    add_known(1'b1, 127, 127, 0, 1'b0);
    add_known(1'b0, 126, 127, 1, 1'b0);
    add_known(1'b0, 127, 126, 1, 1'b0);
    // A 2 x 2 grid walked to its last cell, then wrapping back to the center.
    add_write(REG_NUM_ROWS, 8'd2);
    add_write(REG_NUM_COLS, 8'd2);
    add_write(REG_CENTER_ROW, 8'd0);
    add_write(REG_CENTER_COL, 8'd0);
    add_known(1'b1, 0, 0, 0, 1'b0);
    add_known(1'b0, 0, 1, 1, 1'b0);
    add_known(1'b0, 1, 0, 1, 1'b0);
    add_known(1'b0, 1, 1, 2, 1'b1);
    add_known(1'b0, 0, 0, 0, 1'b0);
    // A 3 x 3 grid centered in the middle, then grown to 5 rows in the middle
    // of the scan without a restart.
    add_write(REG_NUM_ROWS, 8'd3);
    add_write(REG_NUM_COLS, 8'd3);
    add_write(REG_CENTER_ROW, 8'd1);
    add_write(REG_CENTER_COL, 8'd1);
    add_scan(1'b1);
    add_scan(1'b0);
    add_scan(1'b0);
    add_write(REG_NUM_ROWS, 8'd5);
    add_scan(1'b0);
    add_scan(1'b0);
    add_scan(1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Register writes only happen once the core has delivered everything.
    foreach (script_rows[i]) begin
      if (script_rows[i].act == ACT_WRITE) begin
        if (i == 0 || script_rows[i - 1].act != ACT_WRITE) wait_idle();
        write_reg(script_rows[i].index, script_rows[i].value,
                  i == script_rows.size() - 1 || script_rows[i + 1].act != ACT_WRITE);
      end else begin
        send_request(script_rows[i].restart, script_rows[i].known,
                     script_rows[i].expected);
      end
    end

    // Random phases. Most grids are small so that scans run to completion and
    // wrap; about a quarter use extreme or arbitrary register values. Most
    // phases begin with a restart; the others carry the old walk over into
    // the new configuration.
    issued = 0;
    phase = 0;
    while (issued < RANDOM_REQUESTS) begin
      wait_idle();
      wide = ($urandom_range(3) == 0);
      reg_vals[0] = wide ? pick_wide_dim() : 8'($urandom_range(1, 10));
      reg_vals[1] = wide ? pick_wide_dim() : 8'($urandom_range(1, 10));
      reg_vals[2] = wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 11));
      reg_vals[3] = wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 11));
      // Now and then only some of the registers are rewritten.
      write_mask = (phase % 4 == 3) ? 4'($urandom_range(1, 15)) : 4'hF;
      for (int j = 0; j < 4; j++) begin
        if (write_mask[j])
          write_reg(reg_order[j], reg_vals[j], (write_mask >> (j + 1)) == 4'd0);
      end

      total = grid_span(cfg_rows) * grid_span(cfg_cols);
      n = (total <= 120) ? total + $urandom_range(0, total + 4) : $urandom_range(20, 50);
      if (phase == HOLD_PHASE || phase == PAUSE_PHASE) n += 30;
      if (phase == STEADY_PHASE) begin
        n += 150;
        no_idle = 1'b1;
      end
      // The last phase is trimmed so the total lands exactly on the target.
      if (n > RANDOM_REQUESTS - issued) n = RANDOM_REQUESTS - issued;
      restart_first = ($urandom_range(99) < 80);

      for (int i = 0; i < n; i++) begin
        // The receiver holds off while requests keep coming.
        if (phase == HOLD_PHASE && i == 3) hold_req = 1'b1;
        // The sender pauses mid-scan until all results are in.
        if (phase == PAUSE_PHASE && i == 10) wait_idle();
        send_request((i == 0 && restart_first) || ($urandom_range(99) < 3), 1'b0, '0);
      end
      no_idle = 1'b0;
      issued += n;
      phase++;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_cells.size() != 0) begin
      failures++;
      $display("%0d expected cells never arrived", pending_cells.size());
    end
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
